@@ rtl/core/kwhc_pkg.sv @@
package kwhc_pkg;

    typedef enum logic [2:0] {
        CMD_CLEAR_KW = 3'd0,
        CMD_KW_CHAR  = 3'd1,
        CMD_KW_END   = 3'd2,
        CMD_TEXT     = 3'd3,
        CMD_LINE_END = 3'd4,
        CMD_SET_END  = 3'd5
    } t_cmd;

    localparam logic [7:0] HIT_MAX = 8'd255;

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7a)
            || (c >= 8'h41 && c <= 8'h5a);
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
    endfunction

endpackage

@@ rtl/core/keyword_word_hit_counter.sv @@
// Channel | Dir | tdata (low bit up)                                  | tuser | tlast
// s_axis  | in  | command[2:0], character[10:3], zero pad to 16       |  -    |  -
// m_axis  | out | line_index[4:0], hit_count[12:5], overflow[13], pad | kind  | last
// Characters, keyword ends and line ends are taken whenever the output is free.
// An end of set scans the line table, one line a cycle, pausing while a result waits;
// no input is taken meanwhile.
// Reset clears counters and flags; stored text needs none.
// A stalled result register holds off every input until it is taken.
module keyword_word_hit_counter
    import kwhc_pkg::*;
#(
    parameter int NUM_KEYWORDS = 16,
    parameter int MAX_WORD_LEN = 16,
    parameter int MAX_LINES    = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // command, character
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // line_index, hit_count, overflow
    output logic        m_axis_tuser,   // kind
    output logic        m_axis_tlast
);
    localparam int PW = $clog2(MAX_WORD_LEN + 2);
    localparam int KW = $clog2(NUM_KEYWORDS + 1);
    localparam int LW = $clog2(MAX_LINES + 1);
    localparam int LI = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;

    logic [2:0] w_cmd;
    logic [7:0] w_char, w_lc;
    assign w_cmd  = s_axis_tdata[2:0];
    assign w_char = s_axis_tdata[10:3];
    assign w_lc   = to_lower(w_char);

    logic [KW-1:0] r_kw_total;
    logic [PW-1:0] r_load_pos, r_word_pos;
    logic          r_in_word, r_drop, r_scan;
    logic [7:0]    r_line_hits, r_worst;
    logic [LW-1:0] r_line_total, r_scan_idx;
    logic [7:0]    r_counts [MAX_LINES];
    logic          r_ovalid, r_okind, r_olast, r_oovf;
    logic [4:0]    r_oidx;
    logic [7:0]    r_ohits;
    logic [5:0]    r_nout;

    logic out_free, acc;
    assign out_free = !r_ovalid || m_axis_tready;
    assign s_axis_tready = !r_scan && out_free;
    assign acc = s_axis_tvalid && s_axis_tready;

    logic is_text, alnum, fin, clr;
    assign is_text = acc && w_cmd == CMD_TEXT;
    assign alnum   = is_alnum(w_lc);
    assign fin     = (is_text && !alnum) || (acc && w_cmd == CMD_LINE_END);
    assign clr     = fin || (acc && w_cmd == CMD_SET_END);

    logic kw_room;
    assign kw_room = r_kw_total < KW'(NUM_KEYWORDS);

    logic [NUM_KEYWORDS:0] hit_chain;
    assign hit_chain[0] = 1'b0;
    genvar g;
    for (g = 0; g < NUM_KEYWORDS; g++) begin : g_cell
        kwhc_cell #(.MAX_WORD_LEN(MAX_WORD_LEN), .PW(PW)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_wr_char(acc && w_cmd == CMD_KW_CHAR && r_kw_total == KW'(g)
                       && r_load_pos < PW'(MAX_WORD_LEN)),
            .i_load_pos(r_load_pos),
            .i_char(is_text ? w_lc : w_char),
            .i_wr_len(acc && w_cmd == CMD_KW_END && r_kw_total == KW'(g)),
            .i_active(KW'(g) < r_kw_total),
            .i_cmp(is_text && alnum && r_word_pos < PW'(MAX_WORD_LEN)),
            .i_word_pos(r_word_pos),
            .i_clr(clr),
            .i_hit_in(hit_chain[g]),
            .o_hit_out(hit_chain[g+1])
        );
    end

    logic hit;
    logic [7:0] hits_f;
    assign hit = r_in_word && r_word_pos <= PW'(MAX_WORD_LEN) && hit_chain[NUM_KEYWORDS];
    assign hits_f = (hit && r_line_hits != HIT_MAX) ? r_line_hits + 8'd1 : r_line_hits;

    logic [7:0] sc;
    assign sc = r_counts[r_scan_idx[LI-1:0]];

    // any further worst line after the current scan index
    logic more_after;
    always_comb begin
        more_after = 1'b0;
        for (int i = 0; i < MAX_LINES; i++)
            if (LW'(i) > r_scan_idx && LW'(i) < r_line_total && r_counts[i] == r_worst)
                more_after = 1'b1;
    end

    logic scan_emit, out_load;
    assign scan_emit = r_scan && out_free && r_scan_idx < r_line_total
                       && sc == r_worst && r_nout < 6'd32;
    assign out_load  = (acc && w_cmd == CMD_LINE_END) || scan_emit;

    always_ff @(posedge i_clk) begin
        if (acc && w_cmd == CMD_LINE_END && r_line_total < LW'(MAX_LINES))
            r_counts[r_line_total[LI-1:0]] <= hits_f;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kw_total <= '0; r_load_pos <= '0; r_word_pos <= '0; r_in_word <= 1'b0;
            r_line_hits <= '0; r_line_total <= '0; r_worst <= '0; r_drop <= 1'b0;
            r_scan <= 1'b0; r_scan_idx <= '0; r_ovalid <= 1'b0; r_nout <= '0;
        end else begin
            if (out_load)
                r_ovalid <= 1'b1;
            else if (m_axis_tready)
                r_ovalid <= 1'b0;
            if (acc) begin
                unique case (w_cmd)
                    CMD_CLEAR_KW: begin
                        r_kw_total <= '0; r_load_pos <= '0;
                    end
                    CMD_KW_CHAR: if (r_load_pos <= PW'(MAX_WORD_LEN))
                        r_load_pos <= r_load_pos + 1'b1;
                    CMD_KW_END: begin
                        if (kw_room) r_kw_total <= r_kw_total + 1'b1;
                        else r_drop <= 1'b1;
                        r_load_pos <= '0;
                    end
                    CMD_TEXT: begin
                        if (alnum) begin
                            if (r_word_pos <= PW'(MAX_WORD_LEN))
                                r_word_pos <= r_word_pos + 1'b1;
                            r_in_word <= 1'b1;
                        end else begin
                            r_line_hits <= hits_f;
                            r_word_pos <= '0; r_in_word <= 1'b0;
                        end
                    end
                    CMD_LINE_END: begin
                        r_word_pos <= '0; r_in_word <= 1'b0; r_line_hits <= '0;
                        r_okind <= 1'b0; r_olast <= 1'b1;
                        r_ohits <= hits_f;
                        if (r_line_total < LW'(MAX_LINES)) begin
                            r_oidx <= 5'(r_line_total); r_oovf <= r_drop;
                            r_line_total <= r_line_total + 1'b1;
                            if (hits_f > r_worst) r_worst <= hits_f;
                        end else begin
                            r_oidx <= '0; r_oovf <= 1'b1; r_drop <= 1'b1;
                        end
                    end
                    CMD_SET_END: begin
                        r_word_pos <= '0; r_in_word <= 1'b0; r_line_hits <= '0;
                        r_scan <= 1'b1; r_scan_idx <= '0; r_nout <= '0;
                    end
                    default: ;
                endcase
            end else if (r_scan && out_free) begin
                // find next worst line; emit, last marked when none remains or at the 32nd result
                if (r_scan_idx >= r_line_total) begin
                    r_scan <= 1'b0;
                    r_line_total <= '0; r_worst <= '0; r_drop <= 1'b0;
                end else begin
                    r_scan_idx <= r_scan_idx + 1'b1;
                    if (scan_emit) begin
                        r_okind <= 1'b1; r_oidx <= 5'(r_scan_idx);
                        r_ohits <= sc; r_oovf <= r_drop; r_nout <= r_nout + 1'b1;
                        r_olast <= (r_nout == 6'd31) || !more_after;
                    end
                end
            end
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {2'b00, r_oovf, r_ohits, r_oidx};
    assign m_axis_tuser  = r_okind;
    assign m_axis_tlast  = r_olast;
endmodule

@@ rtl/core/kwhc_cell.sv @@
// One dictionary entry: its characters, its length and its candidate bit.
// The match flag ripples along the chain as an or.
module kwhc_cell
    import kwhc_pkg::*;
#(
    parameter int MAX_WORD_LEN = 16,
    parameter int PW = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_char,
    input  logic [PW-1:0] i_load_pos,
    input  logic [7:0]    i_char,
    input  logic          i_wr_len,
    input  logic          i_active,
    input  logic          i_cmp,
    input  logic [PW-1:0] i_word_pos,
    input  logic          i_clr,
    input  logic          i_hit_in,
    output logic          o_hit_out
);
    localparam int IW = $clog2(MAX_WORD_LEN);

    logic [7:0]    r_chars [MAX_WORD_LEN];
    logic [PW-1:0] r_len;
    logic          r_cand;

    always_ff @(posedge i_clk) begin
        if (i_wr_char)
            r_chars[i_load_pos[IW-1:0]] <= i_char;
        if (i_wr_len)
            r_len <= i_load_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_cand <= 1'b1;
        end else if (i_cmp && r_chars[i_word_pos[IW-1:0]] != i_char) begin
            r_cand <= 1'b0;
        end
    end

    assign o_hit_out = i_hit_in | (i_active & r_cand & (r_len == i_word_pos));
endmodule
